### sv/qhsd_pkg.sv
// Shared types, constants and helpers for the quoted hex string decoder.
package qhsd_pkg;

  localparam int unsigned POS_WIDTH_DEF = 16;
  localparam int unsigned FAIL_POS_W    = 16;

  localparam logic [7:0] QUOTE_CH = 8'h27;
  localparam logic [7:0] ZERO_CH  = 8'h30;
  localparam logic [7:0] X_CH     = 8'h78;

  // parse phase, one-hot
  typedef enum logic [5:0] {
    PH_START  = 6'b000001,
    PH_WANT_X = 6'b000010,
    PH_HEX1   = 6'b000100,
    PH_HEX2   = 6'b001000,
    PH_LIT    = 6'b010000,
    PH_QUOTE  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic                  byte_valid;
    logic [7:0]            data;
    logic                  done_res;
    logic                  failed;
    logic [FAIL_POS_W-1:0] fail_pos;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } nibble_t;

  function automatic nibble_t nibble_of(input logic [7:0] c);
    nibble_t n;
    n.ok    = 1'b1;
    n.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39)      n.value = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) n.value = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) n.value = 4'(c - 8'h37);
    else                               n.ok    = 1'b0;
    return n;
  endfunction

endpackage

### sv/qhsd_parser.sv
// Parser state and per-character decode logic.
module qhsd_parser import qhsd_pkg::*; #(
  parameter int unsigned POS_WIDTH = POS_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] ch,
  input  logic       last,
  output result_t    res
);

  localparam int unsigned FPW = (POS_WIDTH > FAIL_POS_W) ? POS_WIDTH : FAIL_POS_W;

  phase_t               phase, phase_next;
  logic [3:0]           high_nibble, high_nibble_next;
  logic [POS_WIDTH-1:0] pos, len;
  logic                 error_seen;

  nibble_t              nib;
  logic                 bv, fail, fail_at_len, at_end_bad;
  logic [7:0]           byte_val;
  logic [POS_WIDTH-1:0] fpos;
  logic [FPW-1:0]       fpos_ext;

  assign nib = nibble_of(ch);
  assign len = pos + POS_WIDTH'(1);

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    bv               = 1'b0;
    byte_val         = 8'd0;
    fail             = 1'b0;
    fail_at_len      = 1'b0;
    at_end_bad       = 1'b0;
    if (!error_seen) begin
      unique case (phase)
        PH_START: begin
          if (ch == QUOTE_CH) begin
            phase_next = PH_LIT;
            at_end_bad = last;
          end else if (ch == ZERO_CH) begin
            phase_next = PH_WANT_X;
            at_end_bad = last;
          end else begin
            fail = 1'b1;
          end
        end
        PH_WANT_X: begin
          if (ch == X_CH) begin
            phase_next = PH_HEX1;
            at_end_bad = last;
          end else begin
            fail = 1'b1;
          end
        end
        PH_HEX1: begin
          if (ch == QUOTE_CH) begin
            phase_next = PH_LIT;
            at_end_bad = last;
          end else if (nib.ok) begin
            high_nibble_next = nib.value;
            phase_next       = PH_HEX2;
            at_end_bad       = last;
          end else begin
            fail = 1'b1;
          end
        end
        PH_HEX2: begin
          if (nib.ok) begin
            bv         = 1'b1;
            byte_val   = {high_nibble, nib.value};
            phase_next = PH_HEX1;
          end else begin
            fail = 1'b1;
          end
        end
        PH_LIT: begin
          if (ch == QUOTE_CH) begin
            phase_next = PH_QUOTE;
          end else begin
            bv         = 1'b1;
            byte_val   = ch;
            at_end_bad = last;
          end
        end
        PH_QUOTE: begin
          if (ch == QUOTE_CH) begin
            bv         = 1'b1;
            byte_val   = QUOTE_CH;
            phase_next = PH_LIT;
            at_end_bad = last;
          end else if (last) begin
            // single trailing char after a closing quote: hex digit fails at the end
            fail        = 1'b1;
            fail_at_len = nib.ok;
          end else if (ch == ZERO_CH) begin
            phase_next = PH_WANT_X;
          end else begin
            fail = 1'b1;
          end
        end
        default: begin
          fail = 1'b1;
        end
      endcase
      if (!fail && at_end_bad) begin
        fail        = 1'b1;
        fail_at_len = 1'b1;
      end
    end
  end

  assign fpos     = fail_at_len ? len : pos;
  assign fpos_ext = FPW'(fpos);

  always_comb begin
    res.byte_valid = bv;
    res.data       = byte_val;
    res.done_res   = last;
    res.failed     = fail;
    res.fail_pos   = fail ? fpos_ext[FAIL_POS_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      high_nibble <= 4'd0;
      pos         <= '0;
      error_seen  <= 1'b0;
    end else if (step) begin
      if (last) begin
        phase       <= PH_START;
        high_nibble <= 4'd0;
        pos         <= '0;
        error_seen  <= 1'b0;
      end else begin
        phase       <= phase_next;
        high_nibble <= high_nibble_next;
        pos         <= len;
        error_seen  <= error_seen | fail;
      end
    end
  end

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    step && last |=> phase == PH_START && pos == '0 && !error_seen)
    else $error("parser did not re-arm after last character");

  a_quiet_after_err: assert property (@(posedge clk) disable iff (rst)
    error_seen |-> !res.failed && !res.byte_valid)
    else $error("output produced after sticky error");

  a_err_sticks: assert property (@(posedge clk) disable iff (rst)
    step && res.failed && !last |=> error_seen)
    else $error("error flag not set after failure");

endmodule

### sv/quoted_hex_string_decoder_unit.sv
// Top level: input register, parser, result register.
// The result reaches m_* through the input register and then the result register.
// Throughput: one character per cycle while m_tready allows; parser state updates per step.
// Backpressure: input stage refills while the result register drains.
// Reset (rst, synchronous): clears both stage valids and returns the parser to start.
module quoted_hex_string_decoder_unit import qhsd_pkg::*; #(
  parameter int unsigned POS_WIDTH = POS_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [0] byte_valid, [8:1] data, [9] failed, [25:10] fail_pos
  output logic        m_tlast    // done_res
);

  logic       in_valid;
  logic [7:0] in_ch;
  logic       in_last;
  logic       advance, step;
  result_t    res, out_res;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_ch   <= s_tdata;
      in_last <= s_tlast;
    end
  end

  qhsd_parser #(.POS_WIDTH(POS_WIDTH)) u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .ch   (in_ch),
    .last (in_last),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
    if (step) begin
      out_res <= res;
    end
  end

  assign m_tdata = {6'd0, out_res.fail_pos, out_res.failed, out_res.data, out_res.byte_valid};
  assign m_tlast = out_res.done_res;

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_res.byte_valid |-> out_res.data == 8'd0)
    else $error("data non-zero without a byte");

  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_res.failed |-> out_res.fail_pos == '0)
    else $error("fail_pos non-zero without failure");

  a_step_fills: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("parsed request lost before result register");

endmodule

### bench/tb_quoted_hex_string_decoder_unit.sv
// Self-checking bench for the quoted hex string decoder: directed strings, random strings, stalls.
`timescale 1ns / 100ps

module tb_quoted_hex_string_decoder_unit;
  import qhsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 50_000;
  localparam logic [7:0]  LC_A = "a";
  localparam logic [7:0]  UC_A = "A";
  localparam logic [7:0]  NONQUOTE_SUB = 8'h28;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;  // [0] byte_valid, [8:1] data, [9] failed, [25:10] fail_pos
  logic        m_tlast;  // done_res

  quoted_hex_string_decoder_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // parser mirror
  phase_t      cur_phase = PH_START;
  logic [3:0]  pend_nib  = 4'd0;
  logic [15:0] char_pos  = 16'd0;
  logic        err_flag  = 1'b0;

  result_t     pending_results[$];
  logic [7:0]  str[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  int unsigned cycles         = 0;
  int unsigned mismatches     = 0;
  int unsigned chars_sent     = 0;
  int unsigned strings_sent   = 0;
  int unsigned bytes_seen     = 0;
  int unsigned fails_seen     = 0;

  function automatic result_t decode_char(input logic [7:0] c, input logic l);
    result_t     r;
    logic [15:0] p;
    logic [15:0] len;
    logic        bad_end;
    logic        hex_ok;
    logic [3:0]  nv;
    r       = '0;
    p       = char_pos;
    len     = char_pos + 16'd1;
    bad_end = 1'b0;
    hex_ok  = 1'b1;
    nv      = 4'd0;
    if (c >= ZERO_CH && c <= ZERO_CH + 8'd9) nv = c[3:0];
    else if (c >= LC_A && c <= LC_A + 8'd5) nv = c[3:0] + 4'd9;
    else if (c >= UC_A && c <= UC_A + 8'd5) nv = c[3:0] + 4'd9;
    else hex_ok = 1'b0;

    if (!err_flag) begin
      case (cur_phase)
        PH_START: begin
          if (c == QUOTE_CH) begin
            cur_phase = PH_LIT;
            bad_end = l;
          end else if (c == ZERO_CH) begin
            cur_phase = PH_WANT_X;
            bad_end = l;
          end else begin
            r.failed = 1'b1;
            r.fail_pos = p;
          end
        end
        PH_WANT_X: begin
          if (c == X_CH) begin
            cur_phase = PH_HEX1;
            bad_end = l;
          end else begin
            r.failed = 1'b1;
            r.fail_pos = p;
          end
        end
        PH_HEX1: begin
          if (c == QUOTE_CH) begin
            cur_phase = PH_LIT;
            bad_end = l;
          end else if (hex_ok) begin
            pend_nib = nv;
            cur_phase = PH_HEX2;
            bad_end = l;
          end else begin
            r.failed = 1'b1;
            r.fail_pos = p;
          end
        end
        PH_HEX2: begin
          if (hex_ok) begin
            r.byte_valid = 1'b1;
            r.data = {pend_nib, nv};
            cur_phase = PH_HEX1;
          end else begin
            r.failed = 1'b1;
            r.fail_pos = p;
          end
        end
        PH_LIT: begin
          if (c == QUOTE_CH) begin
            cur_phase = PH_QUOTE;
          end else begin
            r.byte_valid = 1'b1;
            r.data = c;
            bad_end = l;
          end
        end
        PH_QUOTE: begin
          if (c == QUOTE_CH) begin
            // doubled quote inside a literal
            r.byte_valid = 1'b1;
            r.data = QUOTE_CH;
            cur_phase = PH_LIT;
            bad_end = l;
          end else if (l) begin
            // single trailing char after a closing quote is read as hex
            r.failed = 1'b1;
            r.fail_pos = hex_ok ? len : p;
          end else if (c == ZERO_CH) begin
            cur_phase = PH_WANT_X;
          end else begin
            r.failed = 1'b1;
            r.fail_pos = p;
          end
        end
        default: begin
          r.failed = 1'b1;
          r.fail_pos = p;
        end
      endcase
      if (!r.failed && bad_end) begin
        r.failed = 1'b1;
        r.fail_pos = len;
      end
      if (r.failed) err_flag = 1'b1;
    end

    char_pos = len;
    r.done_res = l;
    if (l) begin
      cur_phase = PH_START;
      pend_nib  = 4'd0;
      char_pos  = 16'd0;
      err_flag  = 1'b0;
    end
    return r;
  endfunction

  // receiver: random stalls, or a forced hold-off while hold_left runs down
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t got;
    result_t exp;
    if (!rst && m_tvalid && m_tready) begin
      got.byte_valid = m_tdata[0];
      got.data       = m_tdata[8:1];
      got.failed     = m_tdata[9];
      got.fail_pos   = m_tdata[25:10];
      got.done_res   = m_tlast;
      if (got.byte_valid) bytes_seen++;
      if (got.failed) fails_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: bv=%0b data=%02h last=%0b fail=%0b pos=%0d",
                   got.byte_valid, got.data, got.done_res, got.failed, got.fail_pos);
      end else begin
        exp = pending_results.pop_front();
        if (got !== exp || m_tdata[31:26] !== 6'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: exp bv=%0b data=%02h last=%0b fail=%0b pos=%0d",
                      " | got bv=%0b data=%02h last=%0b fail=%0b pos=%0d pad=%02h"},
                     exp.byte_valid, exp.data, exp.done_res, exp.failed, exp.fail_pos,
                     got.byte_valid, got.data, got.done_res, got.failed, got.fail_pos,
                     m_tdata[31:26]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic l);
    result_t exp_res;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    exp_res = decode_char(c, l);
    pending_results = {pending_results, exp_res};
    chars_sent++;
  endtask

  task automatic add_char(input logic [7:0] c);
    str = {str, c};
  endtask

  task automatic send_string();
    foreach (str[i]) send_char(str[i], i == str.size() - 1);
    strings_sent++;
  endtask

  task automatic load_text(input string s);
    str.delete();
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  // sender pauses until every outstanding result is back
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_digit();
    int unsigned k;
    k = $urandom_range(21);
    if (k < 10) return ZERO_CH + 8'(k);
    if (k < 16) return LC_A + 8'(k - 10);
    return UC_A + 8'(k - 16);
  endfunction

  function automatic logic [7:0] lit_char();
    logic [7:0] c;
    c = 8'($urandom);
    return (c == QUOTE_CH) ? NONQUOTE_SUB : c;
  endfunction

  // well-formed string: alternating literal and hex runs
  task automatic make_good();
    int unsigned segs;
    bit          in_lit;
    int unsigned n;
    str.delete();
    segs   = $urandom_range(1, 3);
    in_lit = $urandom_range(1);
    for (int s = 0; s < segs; s++) begin
      if (in_lit) begin
        add_char(QUOTE_CH);
        n = $urandom_range(0, 5);
        repeat (n) begin
          if ($urandom_range(5) == 0) begin
            add_char(QUOTE_CH);
            add_char(QUOTE_CH);
          end else begin
            add_char(lit_char());
          end
        end
        add_char(QUOTE_CH);
      end else begin
        add_char(ZERO_CH);
        add_char(X_CH);
        // a hex run directly followed by a literal may be empty
        n = (s == segs - 1) ? $urandom_range(1, 3) : $urandom_range(0, 3);
        repeat (n) begin
          add_char(hex_digit());
          add_char(hex_digit());
        end
      end
      in_lit = !in_lit;
    end
  endtask

  task automatic make_random_string();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(99);
    make_good();
    if (kind < 70) begin
      // keep as is
    end else if (kind < 80) begin
      str[$urandom_range(str.size() - 1)] = 8'($urandom);
    end else if (kind < 88) begin
      if (str.size() > 1) void'(str.pop_back());
    end else if (kind < 94) begin
      add_char($urandom_range(1) ? hex_digit() : 8'($urandom));
    end else begin
      str.delete();
      n = $urandom_range(1, 6);
      repeat (n) add_char(8'($urandom));
    end
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    str.delete();
    add_char(8'hFF);                // bad first char
    send_string();
    load_text("0");                 // prefix cut short
    send_string();
    load_text("0x");
    send_string();
    str.delete();                   // null byte inside a literal
    add_char(QUOTE_CH);
    add_char(8'h00);
    add_char(QUOTE_CH);
    send_string();
    load_text("'''");               // doubled quote, then ends in literal
    send_string();
    load_text("'x'5");              // lone hex digit after closing quote
    send_string();
    load_text("0x9Gz");             // bad digit, trailing char ignored
    send_string();
    load_text("0xA'");              // quote in the middle of a hex pair
    send_string();
    wait_drain();
  endtask

  task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct,
                             input int unsigned n_chars);
    int unsigned start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = chars_sent;
    while (chars_sent - start < n_chars) begin
      make_random_string();
      send_string();
    end
    wait_drain();
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left <= 300;
    repeat (4) begin
      make_random_string();
      send_string();
    end
    wait_drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(0, 0, 115);
    test_random(83, 0, 115);
    test_random(0, 83, 115);
    test_random(12, 12, 115);
    test_backpressure();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;
    $display("Sent %0d characters in %0d strings; %0d bytes decoded, %0d failures reported.",
             chars_sent, strings_sent, bytes_seen, fails_seen);
    $display("Directed corner strings, idle and stall mixes and a long output hold-off were run.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
